FILE: rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DIGIT_CAP           = 19;
    localparam int QUEUE_DEPTH         = 2;
    localparam int CHAR_WIDTH          = 8;
    localparam int KIND_WIDTH          = 2;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_NUM  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_NEG  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SINGLE = 3'd1,
        ST_CONV   = 3'd2,
        ST_SKIP   = 3'd3,
        ST_EMIT   = 3'd4
    } state_t;

    // Handshake between the queue and its neighbors.
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

FILE: rtl/b2da_front.sv
// Input stage: takes values, sorts them into negative, zero or positive.
module b2da_front #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic signed [VALUE_WIDTH-1:0]                s_value,
    output b2da_pkg::hs_t                                push,
    input  logic                                         push_ready,
    output logic [b2da_pkg::KIND_WIDTH+VALUE_WIDTH-2:0]  push_data
);

    b2da_pkg::kind_t kind;
    logic [VALUE_WIDTH-2:0] mag;

    always_comb begin
        mag = s_value[VALUE_WIDTH-2:0];
        if (s_value[VALUE_WIDTH-1]) begin
            kind = b2da_pkg::KIND_NEG;
        end else if (mag == '0) begin
            kind = b2da_pkg::KIND_ZERO;
        end else begin
            kind = b2da_pkg::KIND_NUM;
        end
    end

    assign s_ready    = push_ready;
    assign push.valid = s_valid;
    assign push.ready = push_ready;
    assign push_data  = {kind, mag};

endmodule

FILE: rtl/b2da_queue.sv
// Short FIFO between the input stage and the conversion engine.
module b2da_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  b2da_pkg::hs_t      push,
    output logic               push_ready,
    input  logic [WIDTH-1:0]   push_data,
    output b2da_pkg::hs_t      pop,
    input  logic               pop_ready,
    output logic [WIDTH-1:0]   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.ready  = pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/b2da_back.sv
// Conversion engine: shift-and-add-3 to BCD, then one ASCII digit per transfer.
module b2da_back #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  b2da_pkg::hs_t                                pop,
    output logic                                         pop_ready,
    input  logic [b2da_pkg::KIND_WIDTH+VALUE_WIDTH-2:0]  pop_data,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic [b2da_pkg::CHAR_WIDTH-1:0]              m_digit_char,
    output logic                                         m_is_last,
    output logic                                         m_is_empty
);

    localparam int MAG_W    = VALUE_WIDTH - 1;
    // Decimal digits of the largest positive value, capped.
    localparam int NDIG_RAW = (MAG_W * 30103) / 100000 + 1;
    localparam int NDIG     = (NDIG_RAW > b2da_pkg::DIGIT_CAP) ? b2da_pkg::DIGIT_CAP
                                                                 : NDIG_RAW;
    localparam int BCD_W    = NDIG * 4;
    localparam int BIT_CW   = $clog2(VALUE_WIDTH);
    localparam int DIG_CW   = $clog2(NDIG + 1);

    b2da_pkg::state_t state_reg, state_next;
    logic [MAG_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  bcd_adj;
    logic [BIT_CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0] dig_cnt_reg, dig_cnt_next;
    logic              empty_flag_reg, empty_flag_next;

    logic                           out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_WIDTH-1:0] out_char_reg, out_char_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_empty_reg, out_empty_next;

    b2da_pkg::kind_t  q_kind;
    logic [MAG_W-1:0] q_mag;
    logic [3:0]       top_digit;
    logic             out_free;

    assign q_kind    = b2da_pkg::kind_t'(pop_data[b2da_pkg::KIND_WIDTH+MAG_W-1:MAG_W]);
    assign q_mag     = pop_data[MAG_W-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || m_ready;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        bin_next        = bin_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        empty_flag_next = empty_flag_reg;
        pop_ready       = 1'b0;
        out_valid_next  = out_valid_reg && !m_ready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        case (state_reg)
            b2da_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop.valid) begin
                    case (q_kind)
                        b2da_pkg::KIND_NEG: begin
                            empty_flag_next = 1'b1;
                            state_next      = b2da_pkg::ST_SINGLE;
                        end
                        b2da_pkg::KIND_ZERO: begin
                            empty_flag_next = 1'b0;
                            state_next      = b2da_pkg::ST_SINGLE;
                        end
                        default: begin
                            bin_next     = q_mag;
                            bcd_next     = '0;
                            bit_cnt_next = BIT_CW'(MAG_W);
                            state_next   = b2da_pkg::ST_CONV;
                        end
                    endcase
                end
            end
            b2da_pkg::ST_SINGLE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = empty_flag_reg ? b2da_pkg::CHAR_NONE : b2da_pkg::ASCII_ZERO;
                    out_last_next  = 1'b1;
                    out_empty_next = empty_flag_reg;
                    state_next     = b2da_pkg::ST_IDLE;
                end
            end
            b2da_pkg::ST_CONV: begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CW'(1)) begin
                    dig_cnt_next = DIG_CW'(NDIG);
                    state_next   = b2da_pkg::ST_SKIP;
                end
            end
            b2da_pkg::ST_SKIP: begin
                // drop leading zero digits, always keep the last one
                if (top_digit == 4'd0 && dig_cnt_reg != DIG_CW'(1)) begin
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = b2da_pkg::ASCII_ZERO + {4'd0, top_digit};
                    out_last_next  = (dig_cnt_reg == DIG_CW'(1));
                    out_empty_next = 1'b0;
                    bcd_next       = bcd_reg << 4;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CW'(1)) begin
                        state_next = b2da_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= b2da_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg        <= bin_next;
        bcd_reg        <= bcd_next;
        bit_cnt_reg    <= bit_cnt_next;
        dig_cnt_reg    <= dig_cnt_next;
        empty_flag_reg <= empty_flag_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_digit_char = out_char_reg;
    assign m_is_last    = out_last_reg;
    assign m_is_empty   = out_empty_reg;

endmodule

FILE: rtl/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter.
// Converts a signed VALUE_WIDTH-bit integer to its decimal text, one ASCII digit per
// output transfer, most significant first, m_is_last on the final digit. Zero gives
// a single '0'; a negative value gives one transfer with m_is_empty set, a character
// of 0 and m_is_last set. A positive value leaves the queue, goes through
// shift-and-add-3 over its VALUE_WIDTH-1 magnitude bits in the conversion engine,
// drops its leading zero digits and then sends its digits. Dropped and sent digits
// always add up to the digit capacity. A two-entry queue lets the input side take
// new values while the engine is busy.
module binary_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [VALUE_WIDTH-1:0]        s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [b2da_pkg::CHAR_WIDTH-1:0]      m_digit_char,
    output logic                                 m_is_last,
    output logic                                 m_is_empty
);

    localparam int ENTRY_W = b2da_pkg::KIND_WIDTH + VALUE_WIDTH - 1;

    b2da_pkg::hs_t      push, pop;
    logic               push_ready, pop_ready;
    logic [ENTRY_W-1:0] push_data, pop_data;

    b2da_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b2da_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(b2da_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b2da_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop          (pop),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_is_last    (m_is_last),
        .m_is_empty   (m_is_empty)
    );

endmodule

FILE: verif/tb_binary_to_decimal_ascii_core.sv
// Testbench for binary_to_decimal_ascii_core: random and directed values, digit scoreboard.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_core;

    localparam int VW = 32;

    typedef struct {
        logic [b2da_pkg::CHAR_WIDTH-1:0] digit_char;
        logic                            is_last;
        logic                            is_empty;
    } digit_rec_t;

    // Holds the decimal characters still owed by the block, oldest first.
    class digit_scoreboard;
        digit_rec_t pending_digits[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Expands one accepted value into its expected character stream.
        function void note_value(logic signed [VW-1:0] value);
            logic [b2da_pkg::CHAR_WIDTH-1:0] digs[$];
            logic [VW-1:0]                   mag;
            digit_rec_t                      rec;
            if (value < 0) begin
                rec.digit_char = b2da_pkg::CHAR_NONE;
                rec.is_last    = 1'b1;
                rec.is_empty   = 1'b1;
                pending_digits.push_back(rec);
            end else if (value == 0) begin
                rec.digit_char = b2da_pkg::ASCII_ZERO;
                rec.is_last    = 1'b1;
                rec.is_empty   = 1'b0;
                pending_digits.push_back(rec);
            end else begin
                mag = value;
                while (mag != 0) begin
                    digs.push_front(b2da_pkg::ASCII_ZERO
                                    + b2da_pkg::CHAR_WIDTH'(mag % 10));
                    mag = mag / 10;
                end
                foreach (digs[i]) begin
                    rec.digit_char = digs[i];
                    rec.is_last    = (i == digs.size() - 1);
                    rec.is_empty   = 1'b0;
                    pending_digits.push_back(rec);
                end
            end
        endfunction

        function void check_result(logic [b2da_pkg::CHAR_WIDTH-1:0] digit_char,
                                   logic is_last, logic is_empty);
            digit_rec_t want;
            if (pending_digits.size() == 0) begin
                $error("unexpected result: digit_char %0h is_last %0b is_empty %0b",
                       digit_char, is_last, is_empty);
                mismatches++;
                return;
            end
            want = pending_digits.pop_front();
            if (digit_char !== want.digit_char) begin
                $error("digit_char: expected %0h, actual %0h", want.digit_char, digit_char);
                mismatches++;
            end
            if (is_last !== want.is_last) begin
                $error("is_last: expected %0b, actual %0b", want.is_last, is_last);
                mismatches++;
            end
            if (is_empty !== want.is_empty) begin
                $error("is_empty: expected %0b, actual %0b", want.is_empty, is_empty);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_digits.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic signed [VW-1:0]            s_value = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [b2da_pkg::CHAR_WIDTH-1:0] m_digit_char;
    logic                            m_is_last;
    logic                            m_is_empty;

    int gap_pct   = 0;
    int stall_pct = 0;

    digit_scoreboard sb;

    binary_to_decimal_ascii_core #(.VALUE_WIDTH(VW)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit_char(m_digit_char),
        .m_is_last   (m_is_last),
        .m_is_empty  (m_is_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Transfer monitor: both channels sampled at the same edge the block sees.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_value(s_value);
            if (m_valid && m_ready) sb.check_result(m_digit_char, m_is_last, m_is_empty);
        end
    end

    // Holds valid until transfer; drops it only when an idle gap follows.
    task automatic send_value(input logic [VW-1:0] value);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drops valid, lets the monitor log the last transfer, then waits until no results are outstanding.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Mostly magnitudes spread over every digit count, some negatives, some raw words.
    function automatic logic [VW-1:0] pick_value();
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) return $urandom | 32'h8000_0000;
        if (sel < 30) return $urandom;
        if (sel < 33) return '0;
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 32'h7fff_ffff : lo * 10 - 1;
        if (ndig == 1) lo = 1;
        return $urandom_range(hi, lo);
    endfunction

    initial begin
        logic [VW-1:0] directed[$];
        sb = new();
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7,
                     32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'd1000000000,
                     32'd999999999, 32'd1000000001, 32'd123456789, 32'h5555_5555,
                     32'haaaa_aaaa, 32'd1999999999, 32'd2000000000, 32'h8000_0001,
                     32'd0, 32'd65536, 32'd4294};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_value(directed[i]);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            for (int n = 0; n < 100; n++) begin
                if (phase == 2 && n == 50) drain_results();
                send_value(pick_value());
            end
            drain_results();
        end

        stall_pct = 0;
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("PASS binary_to_decimal_ascii_core");
        end else begin
            $display("FAIL binary_to_decimal_ascii_core");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL binary_to_decimal_ascii_core");
        $finish;
    end

endmodule
